FILE: hw/rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared constants for the magnetization renormalizer.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int COMP_WIDTH_DEF = 32;
    localparam int MS_W           = 31;
    localparam int TOL_W          = 16;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int TOLMS_W        = MS_W + TOL_W;
    localparam int MSK_W          = MS_W + TOL_W + 1;

    localparam logic [MODE_W-1:0] MODE_UNSAT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAT   = 2'd1;

    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RESCALED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DRIFT     = 2'd2;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_TOL  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd6554;

endpackage

FILE: hw/rtl/msr_sqrt.sv
// ----------------------------------------------------------------------------
// msr_sqrt
// Pipelined integer square root, one root bit per stage, with a tag carried.
// ----------------------------------------------------------------------------
module msr_sqrt
    import msr_pkg::*;
#(
    parameter int W     = COMP_WIDTH_DEF,
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2*W-1:0]   in_rad,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [W-1:0]     out_root,
    output logic [TAG_W-1:0] out_tag
);

    localparam int SW = 2 * W;
    localparam int RW = W + 3;

    logic             vld_reg  [0:W-1];
    logic [RW-1:0]    rem_reg  [0:W-1];
    logic [W-1:0]     root_reg [0:W-1];
    logic [SW-1:0]    rad_reg  [0:W-1];
    logic [TAG_W-1:0] tag_reg  [0:W-1];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic             cur_vld;
        logic [RW-1:0]    cur_rem;
        logic [W-1:0]     cur_root;
        logic [SW-1:0]    cur_rad;
        logic [TAG_W-1:0] cur_tag;
        logic [RW-1:0]    rem_sh;
        logic [RW-1:0]    trial;
        logic [RW-1:0]    rem_next;
        logic [W-1:0]     root_next;

        if (k == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_rad  = in_rad;
            assign cur_tag  = in_tag;
        end else begin : g_rest
            assign cur_vld  = vld_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_rad  = rad_reg[k-1];
            assign cur_tag  = tag_reg[k-1];
        end

        always_comb begin
            rem_sh = {cur_rem[RW-3:0], cur_rad[SW-1:SW-2]};
            trial  = {1'b0, cur_root, 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {cur_root[W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {cur_root[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_vld;
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= cur_rad << 2;
                tag_reg[k]  <= cur_tag;
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign out_root  = root_reg[W-1];
    assign out_tag   = tag_reg[W-1];

endmodule

FILE: hw/rtl/msr_div.sv
// ----------------------------------------------------------------------------
// msr_div
// Pipelined restoring divider for three numerators sharing one divisor.
// ----------------------------------------------------------------------------
module msr_div
    import msr_pkg::*;
#(
    parameter int DW    = COMP_WIDTH_DEF,
    parameter int QW    = MS_W,
    parameter int TAG_W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0][DW+QW-1:0] in_num,
    input  logic [DW-1:0]         in_den,
    input  logic [TAG_W-1:0]      in_tag,
    output logic                  out_valid,
    output logic [2:0][QW-1:0]    out_quo,
    output logic [TAG_W-1:0]      out_tag
);

    localparam int NW = DW + QW;

    logic                 vld_reg [0:QW-1];
    logic [2:0][NW-1:0]   rem_reg [0:QW-1];
    logic [2:0][QW-1:0]   quo_reg [0:QW-1];
    logic [DW-1:0]        den_reg [0:QW-1];
    logic [TAG_W-1:0]     tag_reg [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic               cur_vld;
        logic [2:0][NW-1:0] cur_rem;
        logic [2:0][QW-1:0] cur_quo;
        logic [DW-1:0]      cur_den;
        logic [TAG_W-1:0]   cur_tag;
        logic [NW-1:0]      trial;
        logic [2:0][NW-1:0] rem_next;
        logic [2:0][QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign cur_vld = in_valid;
            assign cur_rem = in_num;
            assign cur_quo = '0;
            assign cur_den = in_den;
            assign cur_tag = in_tag;
        end else begin : g_rest
            assign cur_vld = vld_reg[k-1];
            assign cur_rem = rem_reg[k-1];
            assign cur_quo = quo_reg[k-1];
            assign cur_den = den_reg[k-1];
            assign cur_tag = tag_reg[k-1];
        end

        always_comb begin
            trial = NW'(cur_den) << (QW - 1 - k);
            for (int c = 0; c < 3; c++) begin
                if (cur_rem[c] >= trial) begin
                    rem_next[c] = cur_rem[c] - trial;
                    quo_next[c] = {cur_quo[c][QW-2:0], 1'b1};
                end else begin
                    rem_next[c] = cur_rem[c];
                    quo_next[c] = {cur_quo[c][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_vld;
            end
            if (en) begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                den_reg[k] <= cur_den;
                tag_reg[k] <= cur_tag;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

FILE: hw/rtl/magnetization_renormalizer.sv
// ----------------------------------------------------------------------------
// magnetization_renormalizer
// Throughput: one cell per cycle; the square root and divider are fully
// pipelined at one bit per stage, and the whole pipe holds while the result
// register waits. Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module magnetization_renormalizer
    import msr_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COMP_WIDTH-1:0] s_mag_x,
    input  logic [COMP_WIDTH-1:0] s_mag_y,
    input  logic [COMP_WIDTH-1:0] s_mag_z,
    input  logic [MS_W-1:0]       s_sat_magnitude,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COMP_WIDTH-1:0] m_out_x,
    output logic [COMP_WIDTH-1:0] m_out_y,
    output logic [COMP_WIDTH-1:0] m_out_z,
    output logic [STATUS_W-1:0]   m_cell_status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [TOL_W-1:0]      cfg_data
);

    localparam int W  = COMP_WIDTH;
    localparam int LO = (W + 1) / 2;
    localparam int HI = W - LO;
    localparam int SW = 2 * W;
    localparam int NW = W + MS_W;
    localparam int EW = W + 32;
    localparam int CW = EW + 16;

    typedef struct packed {
        logic [2:0][W-1:0] raw;
        logic [2:0]        neg;
        logic [MS_W-1:0]   ms;
        logic [TOLMS_W-1:0] tolms;
        logic [MSK_W-1:0]  msk;
        logic [2:0][NW-1:0] num;
    } sq_tag_t;

    typedef struct packed {
        logic [2:0][W-1:0]   raw;
        logic [2:0]          neg;
        logic [STATUS_W-1:0] status;
        logic                scale;
    } dv_tag_t;

    logic [MODE_W-1:0] mode_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic              en;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
            tol_reg  <= TOL_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_MODE) begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end else begin
                tol_reg <= cfg_data;
            end
        end
    end

    // Stage 1: magnitudes and signs.
    logic              v1_reg;
    logic [2:0][W-1:0] raw1_reg, abs1_reg;
    logic [2:0]        neg1_reg;
    logic [MS_W-1:0]   ms1_reg;
    logic [2:0][W-1:0] raw_in;

    assign raw_in = {s_mag_z, s_mag_y, s_mag_x};

    // Stage 2: partial products.
    logic                  v2_reg;
    logic [2:0][W-1:0]     raw2_reg;
    logic [2:0]            neg2_reg;
    logic [MS_W-1:0]       ms2_reg;
    logic [2:0][2*LO-1:0]  ll2_reg;
    logic [2:0][LO+HI-1:0] lh2_reg;
    logic [2:0][2*HI-1:0]  hh2_reg;
    logic [2:0][LO+MS_W-1:0] aml2_reg;
    logic [2:0][HI+MS_W-1:0] amh2_reg;
    logic [TOLMS_W-1:0]    tolms2_reg;
    logic [MSK_W-1:0]      msk2_reg;

    // Stage 3: squares and numerators.
    logic               v3_reg;
    logic [2:0][W-1:0]  raw3_reg;
    logic [2:0]         neg3_reg;
    logic [MS_W-1:0]    ms3_reg;
    logic [2:0][SW-1:0] sq3_reg;
    logic [2:0][NW-1:0] num3_reg;
    logic [TOLMS_W-1:0] tolms3_reg;
    logic [MSK_W-1:0]   msk3_reg;

    // Stage 4: sum of squares.
    logic          v4_reg;
    logic [SW-1:0] sum4_reg;
    sq_tag_t       tag4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
        if (en) begin
            raw1_reg <= raw_in;
            ms1_reg  <= s_sat_magnitude;
            for (int c = 0; c < 3; c++) begin
                neg1_reg[c] <= raw_in[c][W-1];
                abs1_reg[c] <= raw_in[c][W-1] ? (W'(0) - raw_in[c]) : raw_in[c];
            end

            raw2_reg   <= raw1_reg;
            neg2_reg   <= neg1_reg;
            ms2_reg    <= ms1_reg;
            tolms2_reg <= TOLMS_W'(tol_reg) * TOLMS_W'(ms1_reg);
            msk2_reg   <= MSK_W'(ms1_reg) * MSK_W'({1'b1, tol_reg});
            for (int c = 0; c < 3; c++) begin
                ll2_reg[c]  <= (2*LO)'(abs1_reg[c][LO-1:0]) * (2*LO)'(abs1_reg[c][LO-1:0]);
                lh2_reg[c]  <= (LO+HI)'(abs1_reg[c][LO-1:0]) * (LO+HI)'(abs1_reg[c][W-1:LO]);
                hh2_reg[c]  <= (2*HI)'(abs1_reg[c][W-1:LO]) * (2*HI)'(abs1_reg[c][W-1:LO]);
                aml2_reg[c] <= (LO+MS_W)'(abs1_reg[c][LO-1:0]) * (LO+MS_W)'(ms1_reg);
                amh2_reg[c] <= (HI+MS_W)'(abs1_reg[c][W-1:LO]) * (HI+MS_W)'(ms1_reg);
            end

            raw3_reg   <= raw2_reg;
            neg3_reg   <= neg2_reg;
            ms3_reg    <= ms2_reg;
            tolms3_reg <= tolms2_reg;
            msk3_reg   <= msk2_reg;
            for (int c = 0; c < 3; c++) begin
                sq3_reg[c]  <= (SW'(hh2_reg[c]) << (2 * LO))
                             + (SW'(lh2_reg[c]) << (LO + 1))
                             + SW'(ll2_reg[c]);
                num3_reg[c] <= (NW'(amh2_reg[c]) << LO) + NW'(aml2_reg[c]);
            end

            sum4_reg       <= sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
            tag4_reg.raw   <= raw3_reg;
            tag4_reg.neg   <= neg3_reg;
            tag4_reg.ms    <= ms3_reg;
            tag4_reg.tolms <= tolms3_reg;
            tag4_reg.msk   <= msk3_reg;
            tag4_reg.num   <= num3_reg;
        end
    end

    logic                      sq_valid;
    logic [W-1:0]              sq_root;
    logic [$bits(sq_tag_t)-1:0] sq_tag_bits;
    sq_tag_t                   sq_tag;

    msr_sqrt #(
        .W     (W),
        .TAG_W ($bits(sq_tag_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_rad    (sum4_reg),
        .in_tag    (tag4_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag_bits)
    );

    assign sq_tag = sq_tag_t'(sq_tag_bits);

    // Stage 5: drift check and decision.
    logic [EW-1:0]       mag_e, ms_e, diff;
    logic [CW-1:0]       lhs_sat, lhs_uns;
    logic [STATUS_W-1:0] status_next;
    logic                scale_next;

    always_comb begin
        mag_e       = EW'(sq_root);
        ms_e        = EW'(sq_tag.ms);
        diff        = (mag_e > ms_e) ? (mag_e - ms_e) : (ms_e - mag_e);
        lhs_sat     = {diff, 16'b0};
        lhs_uns     = {mag_e, 16'b0};
        status_next = ST_UNCHANGED;
        scale_next  = 1'b0;
        if (sq_tag.ms != '0) begin
            if (mode_reg == MODE_SAT) begin
                if (lhs_sat > CW'(sq_tag.tolms)) begin
                    status_next = ST_DRIFT;
                end else begin
                    status_next = ST_RESCALED;
                    scale_next  = 1'b1;
                end
            end else if (mode_reg == MODE_UNSAT) begin
                if (lhs_uns > CW'(sq_tag.msk)) begin
                    status_next = ST_DRIFT;
                end else if (mag_e > ms_e) begin
                    status_next = ST_RESCALED;
                    scale_next  = 1'b1;
                end
            end
        end
    end

    logic               v5_reg;
    logic [2:0][NW-1:0] num5_reg;
    logic [W-1:0]       mag5_reg;
    dv_tag_t            tag5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= sq_valid;
        end
        if (en) begin
            num5_reg        <= sq_tag.num;
            mag5_reg        <= sq_root;
            tag5_reg.raw    <= sq_tag.raw;
            tag5_reg.neg    <= sq_tag.neg;
            tag5_reg.status <= status_next;
            tag5_reg.scale  <= scale_next;
        end
    end

    logic                        dv_valid;
    logic [2:0][MS_W-1:0]        dv_quo;
    logic [$bits(dv_tag_t)-1:0]  dv_tag_bits;
    dv_tag_t                     dv_tag;

    msr_div #(
        .DW    (W),
        .QW    (MS_W),
        .TAG_W ($bits(dv_tag_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_num    (num5_reg),
        .in_den    (mag5_reg),
        .in_tag    (tag5_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag_bits)
    );

    assign dv_tag = dv_tag_t'(dv_tag_bits);

    // Output stage: saturation to the component range, or the raw components when not rescaled.
    localparam logic [EW-1:0] SIGN_E = EW'(1) << (W - 1);

    logic [2:0][W-1:0] res_next;
    logic [EW-1:0]     qe;

    always_comb begin
        qe = '0;
        for (int c = 0; c < 3; c++) begin
            qe = EW'(dv_quo[c]);
            if (!dv_tag.scale) begin
                res_next[c] = dv_tag.raw[c];
            end else if (dv_tag.neg[c]) begin
                if (qe > SIGN_E) begin
                    qe = SIGN_E;
                end
                res_next[c] = W'(EW'(0) - qe);
            end else begin
                if (qe > SIGN_E - EW'(1)) begin
                    qe = SIGN_E - EW'(1);
                end
                res_next[c] = qe[W-1:0];
            end
        end
    end

    logic                m_valid_reg;
    logic [2:0][W-1:0]   res_reg;
    logic [STATUS_W-1:0] status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
        if (en) begin
            res_reg    <= res_next;
            status_reg <= dv_tag.status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_x       = res_reg[0];
    assign m_out_y       = res_reg[1];
    assign m_out_z       = res_reg[2];
    assign m_cell_status = status_reg;

endmodule

FILE: tb/sv/tb_magnetization_renormalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_magnetization_renormalizer
// Streams grid cells through the renormalizer under several mode and
// tolerance settings and random flow control, and checks every result
// against predicted output components and a predicted rescale or drift status.
// ----------------------------------------------------------------------------
module tb_magnetization_renormalizer;
    import msr_pkg::*;

    localparam int CW = COMP_WIDTH_DEF;

    typedef struct {
        logic [CW-1:0]       x;
        logic [CW-1:0]       y;
        logic [CW-1:0]       z;
        logic [STATUS_W-1:0] status;
    } cell_result_t;

    class renorm_predictor;
        logic [MODE_W-1:0] mode = MODE_RESET;
        logic [TOL_W-1:0]  tol  = TOL_RESET;
        cell_result_t      pending_cells[$];
        int                errors = 0;

        static function longint unsigned vec_length(longint unsigned s);
            longint unsigned r;
            bit [127:0]      t;
            r = 0;
            for (int b = 32; b >= 0; b--) begin
                t = 128'(r | (64'd1 << b));
                if (t * t <= 128'(s)) r = 64'(t);
            end
            return r;
        endfunction

        static function logic [CW-1:0] shrink(bit neg, longint unsigned a,
                                              longint unsigned ms,
                                              longint unsigned mag);
            longint unsigned q;
            q = (mag == 0) ? 0 : a * ms / mag;
            if (neg) begin
                if (q > 64'd2147483648) q = 64'd2147483648;
                return CW'(64'd0 - q);
            end
            if (q > 64'd2147483647) q = 64'd2147483647;
            return CW'(q);
        endfunction

        function void note_cell(logic [CW-1:0] x, logic [CW-1:0] y,
                                logic [CW-1:0] z, logic [MS_W-1:0] sm);
            logic [CW-1:0]   c[3];
            bit              neg[3];
            longint unsigned a[3];
            longint unsigned sum, mag, d, ms, t;
            bit              scale;
            cell_result_t    r;
            c = '{x, y, z};
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = c[i][CW-1];
                a[i] = neg[i] ? 64'(-longint'($signed(c[i]))) : 64'(c[i]);
                sum += a[i] * a[i];
            end
            mag = vec_length(sum);
            ms = 64'(sm);
            t = 64'(tol);
            scale = 0;
            r.status = ST_UNCHANGED;
            if (ms != 0) begin
                if (mode == MODE_SAT) begin
                    d = (mag > ms) ? mag - ms : ms - mag;
                    if ((d << 16) > t * ms) r.status = ST_DRIFT;
                    else begin
                        r.status = ST_RESCALED;
                        scale = 1;
                    end
                end else if (mode == MODE_UNSAT) begin
                    if ((mag << 16) > ms * (64'd65536 + t)) r.status = ST_DRIFT;
                    else if (mag > ms) begin
                        r.status = ST_RESCALED;
                        scale = 1;
                    end
                end
            end
            r.x = scale ? shrink(neg[0], a[0], ms, mag) : x;
            r.y = scale ? shrink(neg[1], a[1], ms, mag) : y;
            r.z = scale ? shrink(neg[2], a[2], ms, mag) : z;
            pending_cells.push_back(r);
        endfunction

        function void check_cell(cell_result_t got);
            cell_result_t e;
            if (pending_cells.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending_cells.pop_front();
            if (got.x !== e.x) begin
                $error("out_x expected %h actual %h", e.x, got.x);
                errors++;
            end
            if (got.y !== e.y) begin
                $error("out_y expected %h actual %h", e.y, got.y);
                errors++;
            end
            if (got.z !== e.z) begin
                $error("out_z expected %h actual %h", e.z, got.z);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("cell_status expected %0d actual %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CW-1:0]       s_mag_x;
    logic [CW-1:0]       s_mag_y;
    logic [CW-1:0]       s_mag_z;
    logic [MS_W-1:0]     s_sat_magnitude;
    logic                m_valid;
    logic                m_ready;
    logic [CW-1:0]       m_out_x;
    logic [CW-1:0]       m_out_y;
    logic [CW-1:0]       m_out_z;
    logic [STATUS_W-1:0] m_cell_status;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [TOL_W-1:0]    cfg_data;

    renorm_predictor pred = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    magnetization_renormalizer dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("tb_magnetization_renormalizer: errors");
        $finish;
    end

    initial begin
        int held;
        held = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (held < hold_cycles) begin
                held++;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pred.check_cell('{m_out_x, m_out_y, m_out_z, m_cell_status});
    end

    task automatic send_cell(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                             logic [MS_W-1:0] ms);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mag_x <= x;
        s_mag_y <= y;
        s_mag_z <= z;
        s_sat_magnitude <= ms;
        do @(posedge aclk); while (!s_ready);
        pred.note_cell(x, y, z, ms);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pred.pending_cells.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [TOL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MODE) pred.mode = data[MODE_W-1:0];
        else pred.tol = data;
        @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] rand_comp();
        logic [CW-1:0] v;
        v = $urandom() >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic send_random_cell();
        logic [CW-1:0]   x, y, z;
        longint unsigned mag, span;
        longint          ms;
        x = rand_comp();
        y = rand_comp();
        z = rand_comp();
        if ($urandom_range(0, 3) == 0) begin
            send_cell($urandom(), $urandom(), $urandom(), MS_W'($urandom()));
        end else begin
            mag = renorm_predictor::vec_length(
                64'(longint'($signed(x)) * longint'($signed(x))) +
                64'(longint'($signed(y)) * longint'($signed(y))) +
                64'(longint'($signed(z)) * longint'($signed(z))));
            span = ((mag * 64'(pred.tol)) >> 16) + 2;
            ms = longint'(mag) - longint'(span) +
                 longint'({$urandom(), $urandom()} % (2 * span + 1));
            if (ms < 0) ms = 0;
            if (ms > 64'h7FFF_FFFF) ms = 64'h7FFF_FFFF;
            send_cell(x, y, z, MS_W'(ms));
        end
    endtask

    task automatic send_directed();
        logic [CW-1:0] mn, mx;
        mn = {1'b1, {(CW-1){1'b0}}};
        mx = {1'b0, {(CW-1){1'b1}}};
        send_cell(0, 0, 0, 0);
        send_cell(0, 0, 0, 1000);
        send_cell(mn, mn, mn, '1);
        send_cell(mx, mx, mx, '1);
        send_cell(mn, 0, 0, '1);
        send_cell(3, 4, 0, 5);
        send_cell(3000, -4000, 0, 4500);
        send_cell(-3000, 4000, 0, 5500);
        send_cell(-3000, 4000, 0, 10000);
        send_cell(1, 0, 0, '1);
        send_cell(-7, 5, -1, 9);
        send_cell(mx, 0, 0, 0);
    endtask

    initial begin
        logic [MODE_W-1:0] modes[8] = '{2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0};
        logic [TOL_W-1:0]  tols[8]  = '{16'd6554, 16'd0, 16'd65535, 16'd65535,
                                        16'd100, 16'd3000, 16'd0, 16'd6554};
        int idle_send[4] = '{0, 66, 0, 35};
        int idle_recv[4] = '{0, 0, 66, 35};
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_mag_x <= '0;
        s_mag_y <= '0;
        s_mag_z <= '0;
        s_sat_magnitude <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MODE;
        cfg_data <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int p = 0; p < 8; p++) begin
            drain_results();
            write_reg(CFG_MODE, TOL_W'(modes[p]));
            write_reg(CFG_TOL, tols[p]);
            send_idle_pct = idle_send[p % 4];
            recv_stall_pct = idle_recv[p % 4];
            if (p < 2) send_directed();
            if (p == 4) begin
                hold_cycles = 300;
                repeat (60) send_random_cell();
            end
            repeat (45) send_random_cell();
        end
        s_valid <= 1'b0;
        while (pred.pending_cells.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (pred.errors == 0 && pred.pending_cells.size() == 0)
            $display("tb_magnetization_renormalizer: clean");
        else
            $display("tb_magnetization_renormalizer: errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/msr_pkg.sv
hw/rtl/msr_sqrt.sv
hw/rtl/msr_div.sv
hw/rtl/magnetization_renormalizer.sv
tb/sv/tb_magnetization_renormalizer.sv
